/* hw/rtl/wvpc_pkg.sv */
// package for the weight/variance pixel converter
// holds widths, payload structs, op codes and the pipeline stage record; no dependencies
package wvpc_pkg;

    localparam int DataWidth   = 32;
    localparam int FracBits    = 16;
    localparam int WideBits    = DataWidth + FracBits;
    localparam int DivPerStage = 2;
    localparam int NumIter     = WideBits / DivPerStage;
    localparam int SqrtBits    = WideBits / 2;
    localparam int SqrtRemBits = SqrtBits + 3;
    localparam int CfgIdxBits  = 2;

    localparam logic [1:0] KIND_RMS      = 2'd0;
    localparam logic [1:0] KIND_VARIANCE = 2'd1;
    localparam logic [1:0] KIND_WEIGHT   = 2'd2;

    localparam logic DIR_TO_VAR    = 1'b0;
    localparam logic DIR_TO_NATIVE = 1'b1;

    localparam logic [CfgIdxBits-1:0] CFG_MAP_KIND  = 2'd0;
    localparam logic [CfgIdxBits-1:0] CFG_DIRECTION = 2'd1;
    localparam logic [CfgIdxBits-1:0] CFG_GAIN_SQ   = 2'd2;
    localparam logic [CfgIdxBits-1:0] CFG_THRESHOLD = 2'd3;

    localparam logic [DataWidth-1:0] BigValue    = '1;
    localparam logic [DataWidth-1:0] GainSqReset = DataWidth'(65536);

    typedef struct packed {
        logic [DataWidth-1:0] pixel_value;
        logic                 last_pixel;
    } t_in;

    typedef struct packed {
        logic [DataWidth-1:0] converted_value;
        logic                 is_big;
        logic                 last_out;
    } t_out;

    typedef struct packed {
        logic [1:0]           map_kind;
        logic                 direction;
        logic [DataWidth-1:0] gain_squared;
        logic [DataWidth-1:0] threshold;
    } t_cfg;

    typedef enum logic [1:0] {
        OP_CONST,
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } t_op;

    typedef struct packed {
        t_op                    op;
        logic [DataWidth-1:0]   x;
        logic [DataWidth-1:0]   mul_b;
        logic [DataWidth-1:0]   gain;
        logic [DataWidth-1:0]   cval;
        logic [DataWidth-1:0]   div_rem;
        logic [WideBits-1:0]    div_q;
        logic [SqrtRemBits-1:0] sq_rem;
        logic [SqrtBits-1:0]    sq_root;
        logic                   last;
    } t_pipe;

endpackage

/* hw/rtl/wvpc_decode.sv */
// entry stage: picks the operation for each pixel from map kind, direction and threshold
// depends on wvpc_pkg
module wvpc_decode (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_vld,
    input  wvpc_pkg::t_in  i_in,
    input  wvpc_pkg::t_cfg i_cfg,
    output logic           o_vld,
    output wvpc_pkg::t_pipe o_pipe
);

    logic            r_vld;
    wvpc_pkg::t_pipe r_pipe;
    wvpc_pkg::t_pipe n_pipe;
    logic [wvpc_pkg::DataWidth-1:0] x;

    assign x = i_in.pixel_value;

    always_comb begin
        n_pipe         = '0;
        n_pipe.x       = x;
        n_pipe.gain    = i_cfg.gain_squared;
        n_pipe.mul_b   = x;
        n_pipe.last    = i_in.last_pixel;
        n_pipe.op      = wvpc_pkg::OP_CONST;
        n_pipe.cval    = x;
        if (i_cfg.direction == wvpc_pkg::DIR_TO_VAR) begin
            case (i_cfg.map_kind)
                wvpc_pkg::KIND_RMS, wvpc_pkg::KIND_VARIANCE: begin
                    if (x == '0) begin
                        n_pipe.cval = '0;
                    end else if (x < i_cfg.threshold) begin
                        n_pipe.op = wvpc_pkg::OP_MUL;
                        if (i_cfg.map_kind == wvpc_pkg::KIND_VARIANCE) begin
                            n_pipe.mul_b = i_cfg.gain_squared;
                        end
                    end else begin
                        n_pipe.cval = wvpc_pkg::BigValue;
                    end
                end
                wvpc_pkg::KIND_WEIGHT: begin
                    if (x > i_cfg.threshold) begin
                        n_pipe.op = wvpc_pkg::OP_DIV;
                    end else begin
                        n_pipe.cval = wvpc_pkg::BigValue;
                    end
                end
                default: n_pipe.cval = x;
            endcase
        end else begin
            case (i_cfg.map_kind)
                wvpc_pkg::KIND_RMS: begin
                    if (x != wvpc_pkg::BigValue) begin
                        n_pipe.op = wvpc_pkg::OP_SQRT;
                    end else begin
                        n_pipe.cval = wvpc_pkg::BigValue;
                    end
                end
                wvpc_pkg::KIND_WEIGHT: begin
                    if (x != wvpc_pkg::BigValue) begin
                        n_pipe.op = wvpc_pkg::OP_DIV;
                    end else begin
                        n_pipe.cval = '0;
                    end
                end
                default: n_pipe.cval = x;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pipe <= n_pipe;
        end
    end

    assign o_vld  = r_vld;
    assign o_pipe = r_pipe;

endmodule

/* hw/rtl/wvpc_iter_stage.sv */
// one pipeline stage of the restoring divider (two quotient bits) and square root (one bit)
// depends on wvpc_pkg
module wvpc_iter_stage #(
    parameter int STAGE = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  wvpc_pkg::t_pipe i_pipe,
    output logic            o_vld,
    output wvpc_pkg::t_pipe o_pipe
);

    localparam int SqBit = wvpc_pkg::SqrtBits - 1 - STAGE;

    logic            r_vld;
    wvpc_pkg::t_pipe r_pipe;
    wvpc_pkg::t_pipe n_pipe;

    logic [wvpc_pkg::WideBits-1:0]    dividend;
    logic [wvpc_pkg::WideBits-1:0]    radicand;
    logic [wvpc_pkg::DataWidth:0]     div_tmp;
    logic [wvpc_pkg::DataWidth-1:0]   div_rem;
    logic [wvpc_pkg::WideBits-1:0]    div_q;
    logic [wvpc_pkg::SqrtRemBits-1:0] sq_tmp;
    logic [wvpc_pkg::SqrtRemBits-1:0] sq_trial;
    logic [1:0]                       sq_pair;

    assign dividend = {i_pipe.gain, {wvpc_pkg::FracBits{1'b0}}};
    assign radicand = {i_pipe.x, {wvpc_pkg::FracBits{1'b0}}};
    assign sq_pair  = radicand[2*SqBit+1 -: 2];

    always_comb begin
        div_rem = i_pipe.div_rem;
        div_q   = i_pipe.div_q;
        div_tmp = '0;
        for (int j = 0; j < wvpc_pkg::DivPerStage; j++) begin
            div_tmp = {div_rem,
                       dividend[wvpc_pkg::WideBits-1-wvpc_pkg::DivPerStage*STAGE-j]};
            if (div_tmp >= {1'b0, i_pipe.x}) begin
                div_tmp = div_tmp - {1'b0, i_pipe.x};
                div_q   = {div_q[wvpc_pkg::WideBits-2:0], 1'b1};
            end else begin
                div_q   = {div_q[wvpc_pkg::WideBits-2:0], 1'b0};
            end
            div_rem = div_tmp[wvpc_pkg::DataWidth-1:0];
        end

        sq_tmp   = {i_pipe.sq_rem[wvpc_pkg::SqrtRemBits-3:0], sq_pair};
        sq_trial = {{(wvpc_pkg::SqrtRemBits-wvpc_pkg::SqrtBits-2){1'b0}},
                    i_pipe.sq_root, 2'b01};

        n_pipe         = i_pipe;
        n_pipe.div_rem = div_rem;
        n_pipe.div_q   = div_q;
        if (sq_tmp >= sq_trial) begin
            n_pipe.sq_rem  = sq_tmp - sq_trial;
            n_pipe.sq_root = {i_pipe.sq_root[wvpc_pkg::SqrtBits-2:0], 1'b1};
        end else begin
            n_pipe.sq_rem  = sq_tmp;
            n_pipe.sq_root = {i_pipe.sq_root[wvpc_pkg::SqrtBits-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pipe <= n_pipe;
        end
    end

    assign o_vld  = r_vld;
    assign o_pipe = r_pipe;

endmodule

/* hw/rtl/wvpc_final.sv */
// last stage: fixed-point multiply, saturation and result select into the output register
// depends on wvpc_pkg
module wvpc_final (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  wvpc_pkg::t_pipe i_pipe,
    output logic            o_vld,
    output wvpc_pkg::t_out  o_out
);

    localparam int DW = wvpc_pkg::DataWidth;
    localparam int FB = wvpc_pkg::FracBits;

    logic           r_vld;
    wvpc_pkg::t_out r_out;
    wvpc_pkg::t_out n_out;

    logic [2*DW-1:0] product;
    logic [DW-1:0]   mul_res;
    logic [DW-1:0]   div_res;
    logic [DW-1:0]   res;

    assign product = {{DW{1'b0}}, i_pipe.x} * {{DW{1'b0}}, i_pipe.mul_b};
    assign mul_res = (|product[2*DW-1:DW+FB]) ? wvpc_pkg::BigValue : product[DW+FB-1:FB];
    assign div_res = (|i_pipe.div_q[wvpc_pkg::WideBits-1:DW]) ? wvpc_pkg::BigValue
                                                               : i_pipe.div_q[DW-1:0];

    always_comb begin
        case (i_pipe.op)
            wvpc_pkg::OP_MUL:  res = mul_res;
            wvpc_pkg::OP_DIV:  res = div_res;
            wvpc_pkg::OP_SQRT: res = DW'(i_pipe.sq_root);
            default:           res = i_pipe.cval;
        endcase
        n_out.converted_value = res;
        n_out.is_big          = (res == wvpc_pkg::BigValue);
        n_out.last_out        = i_pipe.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_out;
        end
    end

    assign o_vld = r_vld;
    assign o_out = r_out;

endmodule

/* hw/rtl/weight_variance_pixel_convert_core.sv */
// top level of the weight/variance pixel converter: config registers and pipeline chain
// depends on wvpc_pkg, wvpc_decode, wvpc_iter_stage, wvpc_final

// One pixel enters per clock unless the pipeline is stalled; it passes through one decode stage,
// 24 stages that each resolve two quotient bits of the divider and one bit of the square
// root, and a final stage holding the multiplier, saturation and the output register.
// The whole pipeline holds while a waiting result is stalled, so nothing is lost.
// Configuration may only be changed while no pixel is in flight.
module weight_variance_pixel_convert_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  wvpc_pkg::t_in                     i_in,
    output logic                              o_valid,
    input  logic                              i_stall,
    output wvpc_pkg::t_out                    o_out,
    input  logic                              i_cfg_we,
    input  logic [wvpc_pkg::CfgIdxBits-1:0]   i_cfg_idx,
    input  logic [wvpc_pkg::DataWidth-1:0]    i_cfg_data
);

    wvpc_pkg::t_cfg  r_cfg;
    logic            en;
    logic            vld   [0:wvpc_pkg::NumIter];
    wvpc_pkg::t_pipe pipe  [0:wvpc_pkg::NumIter];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.map_kind     <= wvpc_pkg::KIND_WEIGHT;
            r_cfg.direction    <= wvpc_pkg::DIR_TO_VAR;
            r_cfg.gain_squared <= wvpc_pkg::GainSqReset;
            r_cfg.threshold    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                wvpc_pkg::CFG_MAP_KIND:  r_cfg.map_kind     <= i_cfg_data[1:0];
                wvpc_pkg::CFG_DIRECTION: r_cfg.direction    <= i_cfg_data[0];
                wvpc_pkg::CFG_GAIN_SQ:   r_cfg.gain_squared <= i_cfg_data;
                wvpc_pkg::CFG_THRESHOLD: r_cfg.threshold    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline holds only when a finished item is waiting
    assign o_stall = o_valid & i_stall;
    assign en      = ~o_stall;

    wvpc_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_valid),
        .i_in    (i_in),
        .i_cfg   (r_cfg),
        .o_vld   (vld[0]),
        .o_pipe  (pipe[0])
    );

    for (genvar k = 0; k < wvpc_pkg::NumIter; k++) begin : g_iter
        wvpc_iter_stage #(
            .STAGE (k)
        ) u_iter (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (vld[k]),
            .i_pipe  (pipe[k]),
            .o_vld   (vld[k+1]),
            .o_pipe  (pipe[k+1])
        );
    end

    wvpc_final u_final (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (vld[wvpc_pkg::NumIter]),
        .i_pipe  (pipe[wvpc_pkg::NumIter]),
        .o_vld   (o_valid),
        .o_out   (o_out)
    );

endmodule

/* hw/rtl/wvpc_checker.sv */
// port-level checker for the pixel converter, bound to the top level
// depends on wvpc_pkg and weight_variance_pixel_convert_core
module wvpc_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_valid,
    input logic           o_stall,
    input logic           o_valid,
    input logic           i_stall,
    input wvpc_pkg::t_out o_out
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out))
        else $error("stalled output item changed");

    a_big_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out.is_big == (o_out.converted_value == wvpc_pkg::BigValue)))
        else $error("is_big does not match converted value");

    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stall not tied to waiting output item");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind weight_variance_pixel_convert_core wvpc_checker u_wvpc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_out   (o_out)
);
